/* hw/rtl/run_length_line_expander_defines.svh */
`ifndef RUN_LENGTH_LINE_EXPANDER_DEFINES_SVH
`define RUN_LENGTH_LINE_EXPANDER_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define RLLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlle check failed");

// next-cycle implication, checked out of reset only
`define RLLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlle check failed");

`endif

/* hw/rtl/rlle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rlle_pkg;

    localparam int LINE_LIMIT_W     = 12;
    localparam int BYTE_W           = 7;
    localparam int LINE_FILL_BITS_D = 12;
    localparam int FIFO_DEPTH_D     = 2;

    localparam logic [LINE_LIMIT_W-1:0] LINE_LIMIT_RST = 12'd80;

    // classified item handed from front to back
    typedef struct packed {
        logic              flush;
        logic [BYTE_W-1:0] value;
        logic              consumed;
    } t_op;

    // one result item
    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] out_byte;
        logic              consumed;
        logic              break_before;
        logic              line_end;
    } t_res;

endpackage
`default_nettype wire

/* hw/rtl/rlle_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module rlle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/rlle_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module rlle_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_stream_byte,
    output rlle_pkg::t_op    o_op
);
    import rlle_pkg::*;

    logic [BYTE_W-1:0] r_last_literal, n_last_literal;
    logic [BYTE_W-1:0] r_repeats_pending, n_repeats_pending;

    always_comb begin
        o_op              = '0;
        n_last_literal    = r_last_literal;
        n_repeats_pending = r_repeats_pending;
        if (i_cmd) begin
            o_op.flush        = 1'b1;
            n_repeats_pending = '0;
        end else if (r_repeats_pending != '0) begin
            o_op.value        = r_last_literal;
            n_repeats_pending = r_repeats_pending - 1'b1;
        end else if (i_stream_byte[7]) begin
            // count -k leaves k-1 copies, which is the inverted low bits
            o_op.value        = r_last_literal;
            o_op.consumed     = 1'b1;
            n_repeats_pending = ~i_stream_byte[BYTE_W-1:0];
        end else begin
            o_op.value     = i_stream_byte[BYTE_W-1:0];
            o_op.consumed  = 1'b1;
            n_last_literal = i_stream_byte[BYTE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_literal    <= '0;
            r_repeats_pending <= '0;
        end else if (i_accept) begin
            r_last_literal    <= n_last_literal;
            r_repeats_pending <= n_repeats_pending;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/rlle_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module rlle_back #(
    parameter int LINE_FILL_BITS = rlle_pkg::LINE_FILL_BITS_D
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_step,
    input  wire rlle_pkg::t_op                      i_op,
    input  wire logic [rlle_pkg::LINE_LIMIT_W-1:0]  i_line_limit,
    output rlle_pkg::t_res                          o_res
);
    import rlle_pkg::*;

    localparam int CMP_W = (LINE_FILL_BITS > LINE_LIMIT_W) ? LINE_FILL_BITS : LINE_LIMIT_W;
    localparam logic [LINE_FILL_BITS-1:0] FILL_MAX = '1;

    logic [LINE_FILL_BITS-1:0] r_line_fill, n_line_fill, fill_base;
    logic [CMP_W-1:0]          fill_x, limit_x;

    assign fill_x  = CMP_W'(r_line_fill);
    assign limit_x = CMP_W'(i_line_limit);

    always_comb begin
        o_res       = '0;
        n_line_fill = r_line_fill;
        fill_base   = r_line_fill;
        if (i_op.flush) begin
            o_res.line_end = (r_line_fill != '0);
            n_line_fill    = '0;
        end else begin
            o_res.has_byte = 1'b1;
            o_res.out_byte = i_op.value;
            o_res.consumed = i_op.consumed;
            if (i_op.value != '0) begin
                if (fill_x >= limit_x) begin
                    o_res.break_before = 1'b1;
                    fill_base          = '0;
                end
                // fill count saturates
                n_line_fill = (fill_base == FILL_MAX) ? fill_base : fill_base + 1'b1;
            end else begin
                o_res.line_end = 1'b1;
                n_line_fill    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_fill <= '0;
        end else if (i_step) begin
            r_line_fill <= n_line_fill;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/run_length_line_expander.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "run_length_line_expander_defines.svh"
// Run-length line expander: each item is a stream byte or a flush, and each gives exactly one
// result. Items are taken at one per cycle sustained while full is low; an item passes both
// queues before its result can be popped. The front decodes literals and repeat counts and
// feeds a small queue; the back tracks the line fill and writes results into an output queue,
// so either side may stall without stopping the other. Queue depth (default two) sets how
// many items can be in flight. While repeats are pending the input byte is not consumed and
// the source should present it again. The line limit is written through the configuration
// channel, which is always ready, and must only be changed while the block is idle.
module run_length_line_expander #(
    parameter int LINE_FILL_BITS = rlle_pkg::LINE_FILL_BITS_D,
    parameter int FIFO_DEPTH     = rlle_pkg::FIFO_DEPTH_D
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               i_cmd,
    input  wire logic [7:0]                         i_stream_byte,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    o_has_byte,
    output logic [rlle_pkg::BYTE_W-1:0]             o_out_byte,
    output logic                                    o_consumed,
    output logic                                    o_break_before,
    output logic                                    o_line_end,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rlle_pkg::LINE_LIMIT_W-1:0]  i_cfg_data
);
    import rlle_pkg::*;

    logic [LINE_LIMIT_W-1:0] r_line_limit;
    t_op  front_op, back_op;
    t_res back_res, out_res;
    logic in_accept, mid_full, mid_empty, out_full, back_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LINE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_limit <= i_cfg_data;
        end
    end

    assign full      = mid_full;
    assign in_accept = push && !mid_full;
    assign back_step = !mid_empty && !out_full;

    rlle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_cmd         (i_cmd),
        .i_stream_byte (i_stream_byte),
        .o_op          (front_op)
    );

    rlle_fifo #(.WIDTH($bits(t_op)), .DEPTH(FIFO_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_op),
        .o_full  (mid_full),
        .i_pop   (back_step),
        .o_data  (back_op),
        .o_empty (mid_empty)
    );

    rlle_back #(.LINE_FILL_BITS(LINE_FILL_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (back_step),
        .i_op         (back_op),
        .i_line_limit (r_line_limit),
        .o_res        (back_res)
    );

    rlle_fifo #(.WIDTH($bits(t_res)), .DEPTH(FIFO_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_step),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_has_byte     = out_res.has_byte;
    assign o_out_byte     = out_res.out_byte;
    assign o_consumed     = out_res.consumed;
    assign o_break_before = out_res.break_before;
    assign o_line_end     = out_res.line_end;

    // a flush result carries no byte and never consumes or breaks
    `RLLE_ASSERT_NOW(a_flush_clean, !empty && !o_has_byte, o_out_byte == '0 && !o_consumed && !o_break_before)
    // a break only comes before a real nonzero byte, which cannot end the line
    `RLLE_ASSERT_NOW(a_break_byte, !empty && o_break_before, o_has_byte && o_out_byte != '0 && !o_line_end)
    // a byte ends the line only when it is the terminator
    `RLLE_ASSERT_NOW(a_end_zero, !empty && o_has_byte && o_line_end, o_out_byte == '0)
    // the limit register takes the written value
    `RLLE_ASSERT_NEXT(a_cfg_write, i_cfg_valid && o_cfg_ready, r_line_limit == $past(i_cfg_data))
endmodule
`default_nettype wire
